// ===== src/ksrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksrt_pkg
// Shared sizes, field widths and result codes of the key/size registry table.
// ----------------------------------------------------------------------------
package ksrt_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 256;
    localparam int KEY_BITS      = 48;

    // Field widths on the stream ports
    localparam int KEY_FIELD_W  = 48;
    localparam int SIZE_W       = 32;
    localparam int STATUS_W     = 3;
    localparam int IN_DATA_W    = ((KEY_FIELD_W + SIZE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((SIZE_W + 7) / 8) * 8;

    // Stored key width: only the low KEY_BITS bits of the key field take part
    localparam int KEY_W   = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int ENTRY_W = KEY_W + SIZE_W;

    // Index and count widths
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // Item kinds
    localparam logic KIND_REGISTER = 1'b0;
    localparam logic KIND_LOOKUP   = 1'b1;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd5;

    // Write request into the entry store
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [ENTRY_W-1:0] data;
    } ram_wr_t;

    // Read request into the entry store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } ram_rd_t;

endpackage

// ===== src/ksrt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksrt_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No reset; contents are undefined until written.
// ----------------------------------------------------------------------------
module ksrt_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 80,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/key_size_registry_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_size_registry_table
// Bounded key-to-size table searched by a linear scan of an entry RAM.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                         Contents
//  s_*       in   s_tvalid/s_tready/s_tdata/s_tuser  item: key, byte_size, kind
//  m_*       out  m_tvalid/m_tready/m_tdata/m_tuser  result: found_size, status
//
//  An item that needs no search (null key, zero size, empty table) goes from
//  IDLE straight to DONE. A search scans the entry RAM one entry per cycle
//  through its single read port and ends at the first hit or after the last
//  stored entry is compared. Reset clears the state, the entry count, the
//  pending flag and the output valid; the RAM needs no clearing pass.
//  The result waits in an output register; a new item is taken while it waits,
//  and only the DONE state of the next item stalls on an untaken result.
// ----------------------------------------------------------------------------
module key_size_registry_table (
    input  logic                              clk,
    input  logic                              rst_n,
    // item in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ksrt_pkg::IN_DATA_W-1:0]    s_tdata,  // key[47:0], byte_size[79:48]
    input  logic                              s_tuser,  // kind
    // result out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ksrt_pkg::OUT_DATA_W-1:0]   m_tdata,  // found_size[31:0]
    output logic [ksrt_pkg::STATUS_W-1:0]     m_tuser   // status[2:0]
);

    localparam int CNT_W = ksrt_pkg::CNT_W;
    localparam int IDX_W = ksrt_pkg::IDX_W;
    localparam int KEY_W = ksrt_pkg::KEY_W;
    localparam int SIZE_W = ksrt_pkg::SIZE_W;
    localparam int STATUS_W = ksrt_pkg::STATUS_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ksrt_pkg::TABLE_ENTRIES);

    // Controller states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic [CNT_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                kind_reg, kind_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SIZE_W-1:0]   res_size_reg, res_size_next;
    logic [IDX_W-1:0]    wr_idx_reg, wr_idx_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [SIZE_W-1:0]   m_size_reg, m_size_next;

    ksrt_pkg::ram_wr_t        ram_wr;
    ksrt_pkg::ram_rd_t        ram_rd;
    logic [ksrt_pkg::ENTRY_W-1:0] rd_data;
    logic [KEY_W-1:0]         rd_key;
    logic [SIZE_W-1:0]        rd_size;

    logic                in_xfer;
    logic                out_free;
    logic [KEY_W-1:0]    in_key;
    logic [SIZE_W-1:0]   in_size;

    assign in_key  = s_tdata[KEY_W-1:0];
    assign in_size = s_tdata[ksrt_pkg::KEY_FIELD_W +: SIZE_W];
    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign rd_key  = rd_data[SIZE_W +: KEY_W];
    assign rd_size = rd_data[SIZE_W-1:0];

    // Entry store: key above size in each word
    ksrt_ram #(
        .DEPTH (ksrt_pkg::TABLE_ENTRIES),
        .WIDTH (ksrt_pkg::ENTRY_W),
        .ADDR_W(IDX_W)
    ) u_entries (
        .clk    (clk),
        .wr_en  (ram_wr.en),
        .wr_addr(ram_wr.addr),
        .wr_data(ram_wr.data),
        .rd_en  (ram_rd.en),
        .rd_addr(ram_rd.addr),
        .rd_data(rd_data)
    );

    // Controller: accept, scan, write back and hand over the result
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        size_next       = size_reg;
        res_status_next = res_status_reg;
        res_size_next   = res_size_reg;
        wr_idx_next     = wr_idx_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_size_next     = m_size_reg;
        ram_rd.en       = 1'b0;
        ram_rd.addr     = issue_reg[IDX_W-1:0];
        ram_wr.en       = 1'b0;
        ram_wr.addr     = wr_idx_reg;
        ram_wr.data     = {key_reg, size_reg};

        // Drop the waiting result once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    kind_next     = s_tuser;
                    key_next      = in_key;
                    size_next     = in_size;
                    res_size_next = '0;
                    issue_next    = '0;
                    wr_idx_next   = '0;
                    state_next    = S_DONE;
                    if (s_tuser == ksrt_pkg::KIND_REGISTER)
                    begin
                        if ((in_key == '0) || (in_size == '0))
                        begin
                            res_status_next = ksrt_pkg::ST_IGNORED;
                        end
                        else if (count_reg == '0)
                        begin
                            res_status_next = ksrt_pkg::ST_INSERTED;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if ((in_key == '0) || (count_reg == '0))
                        begin
                            res_status_next = ksrt_pkg::ST_MISSING;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next read while the previous word is compared
                if (issue_reg < count_reg)
                begin
                    ram_rd.en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg;
                    issue_next    = issue_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (rd_key == key_reg)
                    begin
                        pend_next   = 1'b0;
                        state_next  = S_DONE;
                        wr_idx_next = pend_idx_reg[IDX_W-1:0];
                        if (kind_reg == ksrt_pkg::KIND_REGISTER)
                        begin
                            res_status_next = ksrt_pkg::ST_UPDATED;
                        end
                        else
                        begin
                            res_status_next = ksrt_pkg::ST_FOUND;
                            res_size_next   = rd_size;
                        end
                    end
                    else if (pend_idx_reg == (count_reg - 1'b1))
                    begin
                        pend_next   = 1'b0;
                        state_next  = S_DONE;
                        wr_idx_next = count_reg[IDX_W-1:0];
                        if (kind_reg == ksrt_pkg::KIND_LOOKUP)
                        begin
                            res_status_next = ksrt_pkg::ST_MISSING;
                        end
                        else if (count_reg < FULL_COUNT)
                        begin
                            res_status_next = ksrt_pkg::ST_INSERTED;
                        end
                        else
                        begin
                            res_status_next = ksrt_pkg::ST_DROPPED;
                        end
                    end
                end
            end

            S_DONE:
            begin
                // Commit the entry and load the output register when it is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_size_next   = res_size_reg;
                    state_next    = S_IDLE;
                    if (res_status_reg inside {ksrt_pkg::ST_INSERTED, ksrt_pkg::ST_UPDATED})
                    begin
                        ram_wr.en = 1'b1;
                    end
                    if (res_status_reg == ksrt_pkg::ST_INSERTED)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        issue_reg      <= issue_next;
        pend_idx_reg   <= pend_idx_next;
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        size_reg       <= size_next;
        res_status_reg <= res_status_next;
        res_size_reg   <= res_size_next;
        wr_idx_reg     <= wr_idx_next;
        m_status_reg   <= m_status_next;
        m_size_reg     <= m_size_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = ksrt_pkg::OUT_DATA_W'(m_size_reg);

    // The entry count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond table depth");

    // The count only ever grows by one, and only on an insert commit
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + 1'b1) && ($past(state_reg) == S_DONE)
             && ($past(res_status_reg) == ksrt_pkg::ST_INSERTED)))
        else $error("entry count changed outside an insert");

    // A word under comparison always lies below the entry count
    a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && (state_reg == S_SCAN)) |-> (pend_idx_reg < count_reg))
        else $error("scan compared an unwritten entry");

    // A lookup hit always reports a stored, nonzero size
    a_found_size: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (m_status_reg == ksrt_pkg::ST_FOUND)) |-> (m_size_reg != '0))
        else $error("lookup hit with zero size");

endmodule
